>>> sv/pjq_pkg.sv
`timescale 1ns / 1ps
// Package for the priority job queue: word types, entry layout and codes.
// Used by pjq_mem, pjq_seq, pjq_obuf and priority_job_queue.
package pjq_pkg;

    localparam int PJQ_DEPTH = 8;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [15:0] job_id;
        logic [7:0]  priority_req;
        logic [15:0] burst_time;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_job_id;
        logic [7:0]  out_priority;
        logic [15:0] out_burst_time;
    } t_out_word;

    // One stored job, 40 bits.
    typedef struct packed {
        logic [15:0] job_id;
        logic [7:0]  prio;
        logic [15:0] burst;
    } t_entry;

endpackage

>>> sv/priority_job_queue.sv
`timescale 1ns / 1ps
// Bounded priority queue of up to DEPTH jobs, held in a one-read, one-write job
// store. An insert writes the job at the end of the store. A remove of the best
// of the held jobs scans the store one entry per cycle, then moves the jobs
// behind it one place forward; the single read port of the store sets the length
// of a remove. A new word is taken once the previous result has left the
// sequencer; the output register can still be holding it for the consumer.
// Ties on priority go to the latest-inserted job.
// Depends on pjq_pkg, pjq_mem, pjq_seq and pjq_obuf.
module priority_job_queue
    import pjq_pkg::*;
#(
    parameter int DEPTH = PJQ_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic          w_res_valid;
    logic          w_res_ready;
    t_out_word     w_res_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;
    logic [CW-1:0] w_count;

    pjq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pjq_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res_data    (w_res_data),
        .o_mem_wr_en   (w_wr_en),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_data (w_wr_data),
        .o_mem_rd_addr (w_rd_addr),
        .i_mem_rd_data (w_rd_data),
        .o_count       (w_count)
    );

    pjq_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(DEPTH))
        else $error("job count above depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word taken while one is in work");

    a_count_moves_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count != $past(w_count)) |->
            (w_count == $past(w_count) + CW'(1) || w_count == $past(w_count) - CW'(1)))
        else $error("job count jumped");

    a_failed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_data.status != ST_DONE) |->
            (w_res_data.out_job_id == '0 && w_res_data.out_priority == '0
             && w_res_data.out_burst_time == '0))
        else $error("failed operation carries job data");

endmodule

>>> sv/pjq_mem.sv
`timescale 1ns / 1ps
// Job store: one write port, one read port, read data registered.
// Depends on pjq_pkg for the entry layout.
module pjq_mem
    import pjq_pkg::*;
#(
    parameter int DEPTH = PJQ_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/pjq_seq.sv
`timescale 1ns / 1ps
// Sequencer: appends on insert, scans for the best entry and compacts on remove.
// Depends on pjq_pkg; drives the ports of pjq_mem.
module pjq_seq
    import pjq_pkg::*;
#(
    parameter int DEPTH = PJQ_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_word      i_in_data,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_out_word     o_res_data,
    output logic          o_mem_wr_en,
    output logic [AW-1:0] o_mem_wr_addr,
    output t_entry        o_mem_wr_data,
    output logic [AW-1:0] o_mem_rd_addr,
    input  t_entry        i_mem_rd_data,
    output logic [CW-1:0] o_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_res_valid, n_res_valid;
    t_out_word     r_res, n_res;
    logic [AW-1:0] r_ridx, n_ridx;
    logic [AW-1:0] r_best, n_best;
    t_entry        r_best_entry, n_best_entry;
    logic [CW-1:0] r_src, n_src;
    logic [AW-1:0] r_dst, n_dst;
    logic          r_pend, n_pend;

    logic          take_new;
    logic          issue;
    logic [AW-1:0] best_idx;
    t_entry        in_entry;

    assign in_entry.job_id = i_in_data.job_id;
    assign in_entry.prio   = i_in_data.priority_req;
    assign in_entry.burst  = i_in_data.burst_time;

    assign o_in_ready = (r_state == S_IDLE) && !r_res_valid;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res_valid  = r_res_valid;
        n_res        = r_res;
        n_ridx       = r_ridx;
        n_best       = r_best;
        n_best_entry = r_best_entry;
        n_src        = r_src;
        n_dst        = r_dst;
        n_pend       = r_pend;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_count[AW-1:0];
        o_mem_wr_data = in_entry;
        o_mem_rd_addr = '0;
        // the first entry read always becomes the candidate; later ones win ties
        take_new = (r_ridx == '0) || (i_mem_rd_data.prio >= r_best_entry.prio);
        best_idx = take_new ? r_ridx : r_best;
        issue    = (r_src < r_count);

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in_data.func == FN_INSERT) begin
                        n_res       = '0;
                        n_res_valid = 1'b1;
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status = ST_OVERFLOW;
                        end else begin
                            o_mem_wr_en  = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_res.status = ST_DONE;
                        end
                    end else if (r_count == '0) begin
                        n_res        = '0;
                        n_res.status = ST_UNDERFLOW;
                        n_res_valid  = 1'b1;
                    end else begin
                        o_mem_rd_addr = '0;
                        n_ridx        = '0;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (take_new) begin
                    n_best       = r_ridx;
                    n_best_entry = i_mem_rd_data;
                end
                if (CW'(r_ridx) + CW'(1) == r_count) begin
                    n_src   = CW'(best_idx) + CW'(1);
                    n_dst   = best_idx;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    o_mem_rd_addr = r_ridx + AW'(1);
                    n_ridx        = r_ridx + AW'(1);
                end
            end
            S_SHIFT: begin
                // read the next entry behind the gap while writing the last one forward
                if (issue) begin
                    o_mem_rd_addr = r_src[AW-1:0];
                    n_src         = r_src + CW'(1);
                end
                n_pend = issue;
                if (r_pend) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = r_dst;
                    o_mem_wr_data = i_mem_rd_data;
                    n_dst         = r_dst + AW'(1);
                end
                if (!issue && !r_pend) begin
                    n_count              = r_count - CW'(1);
                    n_res.status         = ST_DONE;
                    n_res.out_job_id     = r_best_entry.job_id;
                    n_res.out_priority   = r_best_entry.prio;
                    n_res.out_burst_time = r_best_entry.burst;
                    n_res_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res        <= n_res;
        r_ridx       <= n_ridx;
        r_best       <= n_best;
        r_best_entry <= n_best_entry;
        r_src        <= n_src;
        r_dst        <= n_dst;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;
    assign o_count     = r_count;

endmodule

>>> sv/pjq_obuf.sv
`timescale 1ns / 1ps
// Output register: holds one result word until the consumer takes it.
// Depends on pjq_pkg for the result word type.
module pjq_obuf
    import pjq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_out_word i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
